>>> src/phm_pkg.sv
// ----------------------------------------------------------------------------
// phm_pkg
// Shared types and constants of the priority handoff mutex: wait-list entry,
// opcodes, status codes, sequencer states, the result word and scan types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phm_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int TID_W       = 8;
  localparam int PRIO_W      = 4;
  localparam int IDX_W       = $clog2(MAX_WAITERS);
  localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_HANDOFF = 2'd1,
    OP_BCAST   = 2'd2,
    OP_RSVD    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_ACQUIRED  = 3'd0,
    STS_BLOCKED   = 3'd1,
    STS_RELEASED  = 3'd2,
    STS_HANDED    = 3'd3,
    STS_WAKE      = 3'd4,
    STS_NOT_OWNED = 3'd5,
    STS_FULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_BCAST
  } state_t;

  typedef struct packed {
    status_t          status;
    logic             woken_valid;
    logic [TID_W-1:0] woken_thread;
    logic             must_resched;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             step;
    logic             first;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } scan_best_t;

endpackage

`default_nettype wire

>>> src/priority_handoff_mutex_top.sv
// ----------------------------------------------------------------------------
// priority_handoff_mutex_top
// Hardware mutex with a wait list kept in a small memory and a sequencer
// that scans, compacts and drains the list one entry per cycle, draining only while the result side keeps up.
// ----------------------------------------------------------------------------
// A lock, a release with no waiters and any refused request get their result
// word in the cycle after they are taken. A handoff unlock with n waiters
// scans the list through the single read port of the wait-list memory and the
// shared priority comparator, moves up to n-1 entries one place down to close
// the gap, and issues the result once the result register is free. A broadcast
// unlock issues one word per cycle, n in all, while the result side takes them.
// The block takes a new word only when the sequencer is idle and the result
// register is free or being emptied.
`timescale 1ns / 1ps
`default_nettype none

module priority_handoff_mutex_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_thread_id,
  input  wire logic [3:0] in_thread_prio,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic            out_woken_valid,
  output logic [7:0]      out_woken_thread,
  output logic            out_must_reschedule,
  output logic            out_last
);

  localparam int IDX_W = phm_pkg::IDX_W;
  localparam int CNT_W = phm_pkg::CNT_W;

  phm_pkg::state_t  state_r, state_nxt;
  logic             owner_valid_r, owner_valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  phm_pkg::result_t res_r, res_nxt;
  logic             res_load;

  phm_pkg::entry_t  mem [phm_pkg::MAX_WAITERS];
  phm_pkg::entry_t  rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  phm_pkg::entry_t  wr_data;

  phm_pkg::scan_ctl_t  scan_ctl;
  phm_pkg::scan_best_t best;

  phm_pkg::op_t     op;
  logic             out_free;
  logic             in_acc;
  logic [CNT_W-1:0] cnt_m1;
  logic             bc_last;

  phm_scan_unit u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .rd_data (rd_data_r),
    .best    (best)
  );

  assign op       = phm_pkg::op_t'(in_opcode);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == phm_pkg::S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign cnt_m1   = count_r - CNT_W'(1);
  assign bc_last  = (idx_r == cnt_m1);
  assign rd_addr  = idx_nxt[IDX_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    owner_valid_nxt = owner_valid_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    res_load        = 1'b0;
    res_nxt         = res_r;
    wr_en           = 1'b0;
    wr_addr         = count_r[IDX_W-1:0];
    wr_data         = '{tid: in_thread_id, prio: in_thread_prio};
    scan_ctl        = '{step: 1'b0, first: 1'b0, idx: idx_r[IDX_W-1:0]};

    unique case (state_r)
      phm_pkg::S_IDLE: begin
        if (in_acc) begin
          res_load = 1'b1;
          res_nxt  = '{status: phm_pkg::STS_NOT_OWNED, woken_valid: 1'b0,
                       woken_thread: '0, must_resched: 1'b0, last: 1'b1};
          unique case (op) inside
            phm_pkg::OP_LOCK: begin
              if (!owner_valid_r) begin
                owner_valid_nxt      = 1'b1;
                count_nxt            = '0;
                res_nxt.status       = phm_pkg::STS_ACQUIRED;
                res_nxt.woken_thread = in_thread_id;
              end else if (count_r >= CNT_W'(phm_pkg::MAX_WAITERS)) begin
                res_nxt.status = phm_pkg::STS_FULL;
              end else begin
                wr_en                = 1'b1;
                count_nxt            = count_r + CNT_W'(1);
                res_nxt.status       = phm_pkg::STS_BLOCKED;
                res_nxt.must_resched = 1'b1;
              end
            end
            phm_pkg::OP_HANDOFF, phm_pkg::OP_BCAST: begin
              if (!owner_valid_r) begin
                res_nxt.status = phm_pkg::STS_NOT_OWNED;
              end else if (count_r == '0) begin
                owner_valid_nxt = 1'b0;
                res_nxt.status  = phm_pkg::STS_RELEASED;
              end else begin
                res_load  = 1'b0;
                idx_nxt   = '0;
                state_nxt = (op == phm_pkg::OP_HANDOFF) ? phm_pkg::S_SCAN
                                                        : phm_pkg::S_BCAST;
              end
            end
            default: begin
              res_nxt.status = phm_pkg::STS_NOT_OWNED;
            end
          endcase
        end
      end

      phm_pkg::S_SCAN: begin
        scan_ctl.step  = 1'b1;
        scan_ctl.first = (idx_r == '0);
        if (idx_r == cnt_m1) begin
          // compaction starts with the entry just after the winner
          idx_nxt   = CNT_W'(best.idx) + CNT_W'(1);
          state_nxt = phm_pkg::S_MOVE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      phm_pkg::S_MOVE: begin
        if (idx_r < count_r) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(idx_r - CNT_W'(1));
          wr_data = rd_data_r;
          idx_nxt = idx_r + CNT_W'(1);
        end else if (out_free) begin
          res_load  = 1'b1;
          res_nxt   = '{status: phm_pkg::STS_HANDED, woken_valid: 1'b1,
                        woken_thread: best.entry.tid, must_resched: 1'b1,
                        last: 1'b1};
          count_nxt = cnt_m1;
          state_nxt = phm_pkg::S_IDLE;
        end
      end

      phm_pkg::S_BCAST: begin
        if (out_free) begin
          res_load = 1'b1;
          res_nxt  = '{status: phm_pkg::STS_WAKE, woken_valid: 1'b1,
                       woken_thread: rd_data_r.tid, must_resched: 1'b1,
                       last: bc_last};
          if (bc_last) begin
            count_nxt = '0;
            state_nxt = phm_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = phm_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = res_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= phm_pkg::S_IDLE;
      owner_valid_r <= 1'b0;
      count_r       <= '0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      owner_valid_r <= owner_valid_nxt;
      count_r       <= count_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  // wait-list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_woken_valid     = res_r.woken_valid;
  assign out_woken_thread    = res_r.woken_thread;
  assign out_must_reschedule = res_r.must_resched;
  assign out_last            = res_r.last;

endmodule

`default_nettype wire

>>> src/phm_scan_unit.sv
// ----------------------------------------------------------------------------
// phm_scan_unit
// Shared priority comparator: folds one wait-list entry per step into the
// running minimum, keeping the earliest entry on equal priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phm_scan_unit (
  input  wire logic               clk,
  input  wire phm_pkg::scan_ctl_t ctl,
  input  wire phm_pkg::entry_t    rd_data,
  output phm_pkg::scan_best_t     best
);

  phm_pkg::scan_best_t best_r;
  logic                take;

  // strict less-than keeps the earliest waiter on ties
  assign take = ctl.step && (ctl.first || (rd_data.prio < best_r.entry.prio));

  always_comb begin
    if (take) begin
      best.idx   = ctl.idx;
      best.entry = rd_data;
    end else begin
      best = best_r;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best;
  end

endmodule

`default_nettype wire

>>> src/phm_checker.sv
// ----------------------------------------------------------------------------
// phm_checker
// Port-level checks of the priority handoff mutex result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic       out_woken_valid,
  input wire logic [7:0] out_woken_thread,
  input wire logic       out_must_reschedule,
  input wire logic       out_last
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_woken_thread) && $stable(out_last))
    else $error("result word changed while stalled");

  // only a broadcast run has words before its last one
  a_run_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == phm_pkg::STS_WAKE)
    else $error("non-final word outside a broadcast");

  // a waiter leaving the list always forces a reschedule
  a_woken_resched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == phm_pkg::STS_HANDED || out_status == phm_pkg::STS_WAKE)
      |-> out_woken_valid && out_must_reschedule)
    else $error("wake without woken flags");

  // thread field is zero unless someone woke or acquired
  a_thread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_woken_valid && out_status != phm_pkg::STS_ACQUIRED
      |-> out_woken_thread == 8'd0)
    else $error("stray thread id in result");

endmodule

bind priority_handoff_mutex_top phm_checker u_phm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_woken_valid     (out_woken_valid),
  .out_woken_thread    (out_woken_thread),
  .out_must_reschedule (out_must_reschedule),
  .out_last            (out_last)
);

`default_nettype wire
